/* rtl/saturating_divide_64_by_32_macros.svh */
// assertion macros for the saturating 64 by 32 divider
// used by the top level only, expects clk and rst_n in scope
`ifndef SATURATING_DIVIDE_64_BY_32_MACROS_SVH
`define SATURATING_DIVIDE_64_BY_32_MACROS_SVH

// same-cycle implication
`define SD64_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SD64_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/sd64_pkg.sv */
// shared types and constants for the saturating 64 by 32 divider
// no dependencies
package sd64_pkg;

  localparam int unsigned NCELLS = 31;

  localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_NEG = 32'h8000_0000;

  typedef struct packed {
    logic valid;
    logic neg;
    logic sat;
    logic last;
  } sd64_ctl_t;

endpackage

/* rtl/sd64_prep.sv */
// operand conditioning stage: magnitudes, result sign, overflow detect
// depends on sd64_pkg
module sd64_prep
  import sd64_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     accept_i,
  input  logic signed [63:0]       dividend_i,
  input  logic signed [31:0]       divisor_i,
  input  logic                     last_i,
  output sd64_ctl_t                ctl_o,
  output logic [31:0]              rem_o,
  output logic [NCELLS-1:0]        rq_o,
  output logic [31:0]              aden_o
);

  sd64_ctl_t         ctl_r, ctl_nxt;
  logic [31:0]       rem_r, rem_nxt;
  logic [NCELLS-1:0] rq_r, rq_nxt;
  logic [31:0]       aden_r, aden_nxt;
  logic [63:0]       anum;

  always_comb begin
    anum     = dividend_i[63] ? (~dividend_i + 64'd1) : dividend_i;
    aden_nxt = divisor_i[31] ? (~divisor_i + 32'd1) : divisor_i;
    // quotient fits 31 bits only if the upper dividend part is below the divisor
    ctl_nxt.valid = accept_i;
    ctl_nxt.neg   = dividend_i[63] ^ divisor_i[31];
    ctl_nxt.sat   = (aden_nxt == 32'd0) || (anum[63:31] >= {1'b0, aden_nxt});
    ctl_nxt.last  = last_i;
    rem_nxt       = anum[62:31];
    rq_nxt        = anum[NCELLS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    rq_r   <= rq_nxt;
    aden_r <= aden_nxt;
  end

  assign ctl_o  = ctl_r;
  assign rem_o  = rem_r;
  assign rq_o   = rq_r;
  assign aden_o = aden_r;

endmodule

/* rtl/sd64_cell.sv */
// one restoring division cell: retires one quotient bit per beat
// depends on sd64_pkg
module sd64_cell
  import sd64_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  sd64_ctl_t                ctl_i,
  input  logic [31:0]              rem_i,
  input  logic [NCELLS-1:0]        rq_i,
  input  logic [31:0]              aden_i,
  output sd64_ctl_t                ctl_o,
  output logic [31:0]              rem_o,
  output logic [NCELLS-1:0]        rq_o,
  output logic [31:0]              aden_o
);

  sd64_ctl_t         ctl_r;
  logic [31:0]       rem_r, rem_nxt;
  logic [NCELLS-1:0] rq_r, rq_nxt;
  logic [31:0]       aden_r;
  logic [32:0]       shifted;
  logic [33:0]       diff;
  logic              ge;

  // rq holds remaining dividend bits at the top, quotient bits enter at the bottom
  always_comb begin
    shifted = {rem_i, rq_i[NCELLS-1]};
    diff    = {1'b0, shifted} - {2'b00, aden_i};
    ge      = !diff[33];
    rem_nxt = ge ? diff[31:0] : shifted[31:0];
    rq_nxt  = {rq_i[NCELLS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    rq_r   <= rq_nxt;
    aden_r <= aden_i;
  end

  assign ctl_o  = ctl_r;
  assign rem_o  = rem_r;
  assign rq_o   = rq_r;
  assign aden_o = aden_r;

endmodule

/* rtl/saturating_divide_64_by_32.sv */
// pipeline stages from start to out_valid: 1 prep, 31 cells, 1 output
// throughput: one beat per cycle, set by one quotient bit per cell in the chain
// busy is always low; results cannot be held off and leave in order
// reset (synchronous, rst_n low) clears the valid flags of every stage
// depends on sd64_pkg, sd64_prep, sd64_cell and the assertion macro header
`include "saturating_divide_64_by_32_macros.svh"
module saturating_divide_64_by_32
  import sd64_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [63:0] in_dividend,
  input  logic signed [31:0] in_divisor,
  input  logic               in_last_element,
  output logic               out_valid,
  output logic signed [31:0] out_quotient,
  output logic               out_last_result
);

  sd64_ctl_t         ctl_s  [0:NCELLS];
  logic [31:0]       rem_s  [0:NCELLS];
  logic [NCELLS-1:0] rq_s   [0:NCELLS];
  logic [31:0]       aden_s [0:NCELLS];

  sd64_ctl_t   last_ctl;
  logic [31:0] mag;
  logic [31:0] quotient_nxt;
  logic [31:0] quotient_r;
  logic        valid_r;
  logic        last_r;

  assign busy = 1'b0;

  sd64_prep u_prep (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept_i   (start && !busy),
    .dividend_i (in_dividend),
    .divisor_i  (in_divisor),
    .last_i     (in_last_element),
    .ctl_o      (ctl_s[0]),
    .rem_o      (rem_s[0]),
    .rq_o       (rq_s[0]),
    .aden_o     (aden_s[0])
  );

  for (genvar g = 0; g < NCELLS; g++) begin : g_cell
    sd64_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl_i  (ctl_s[g]),
      .rem_i  (rem_s[g]),
      .rq_i   (rq_s[g]),
      .aden_i (aden_s[g]),
      .ctl_o  (ctl_s[g+1]),
      .rem_o  (rem_s[g+1]),
      .rq_o   (rq_s[g+1]),
      .aden_o (aden_s[g+1])
    );
  end

  assign last_ctl = ctl_s[NCELLS];

  always_comb begin
    mag = {1'b0, rq_s[NCELLS]};
    if (last_ctl.sat) begin
      quotient_nxt = last_ctl.neg ? SAT_NEG : SAT_POS;
    end else begin
      quotient_nxt = last_ctl.neg ? (~mag + 32'd1) : mag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= last_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    quotient_r <= quotient_nxt;
    last_r     <= last_ctl.last;
  end

  assign out_valid       = valid_r;
  assign out_quotient    = quotient_r;
  assign out_last_result = last_r;

  `SD64_ASSERT_IMP(a_latency, out_valid, $past(start, NCELLS + 2), "result without a start")
  `SD64_ASSERT_NXT(a_sat_value, last_ctl.valid && last_ctl.sat,
    out_quotient == SAT_POS || out_quotient == SAT_NEG, "saturated result out of range")
  `SD64_ASSERT_NXT(a_pos_sign, last_ctl.valid && !last_ctl.sat && !last_ctl.neg,
    !out_quotient[31], "positive quotient has sign bit set")
  `SD64_ASSERT_IMP(a_rem_bound, last_ctl.valid && !last_ctl.sat,
    rem_s[NCELLS] < aden_s[NCELLS], "final remainder not below divisor")

endmodule
